>>> hw/rtl/ilsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsu_pkg
// Shared types and constants of the lattice site update block.
// ----------------------------------------------------------------------------
package ilsu_pkg;

  // Payload widths fixed by the channel definition
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned SITE_W  = 8;
  localparam int unsigned THR_W   = 8;

  // Words held per update: the site itself and its four neighbours
  localparam int unsigned NB_WORDS = 5;
  localparam int unsigned SEL_W    = 3;

  // Command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic             take;     // latch the incoming item
    logic             div;      // register the row number
    logic             nbr;      // register the five read addresses
    logic [SEL_W-1:0] rd_sel;   // address slot presented to the RAM
    logic             cap_en;   // capture RAM read data
    logic [SEL_W-1:0] cap_sel;  // word slot receiving the read data
    logic             commit;   // write back and load the result register
  } ilsu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic upd_go;               // latched item is an update of a stored site
  } ilsu_sts_t;

endpackage

>>> hw/rtl/ilsu_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsu_in_if
// Command channel: load or update of one lattice site.
// ----------------------------------------------------------------------------
interface ilsu_in_if;
  import ilsu_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [SITE_W-1:0] site;
  logic [THR_W-1:0]  threshold;
  logic [WORD_W-1:0] load_word;

  modport source (output valid, output command, output site, output threshold,
                  output load_word, input ready);
  modport sink   (input valid, input command, input site, input threshold,
                  input load_word, output ready);
endinterface

>>> hw/rtl/ilsu_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsu_out_if
// Result channel: new spin word and flip mask of one site.
// ----------------------------------------------------------------------------
interface ilsu_out_if;
  import ilsu_pkg::*;

  logic              valid;
  logic              ready;
  logic [SITE_W-1:0] out_site;
  logic [WORD_W-1:0] spin_word;
  logic [WORD_W-1:0] flip_mask;

  modport source (output valid, output out_site, output spin_word, output flip_mask,
                  input ready);
  modport sink   (input valid, input out_site, input spin_word, input flip_mask,
                  output ready);
endinterface

>>> hw/rtl/ising_lattice_site_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_lattice_site_update
// Multispin Metropolis update of one site of a periodic square lattice.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one command per transfer: a load writes load_word into the
//   spin store at site, an update reads the site and its four wrapped
//   neighbours, flips every realization whose energy term does not exceed
//   threshold, writes the new word back and reports it with the flip mask.
//   out_o returns exactly one result per command, in command order.
//   Every site must be loaded before an update touches it.
// Timing:
//   A load (or any command to a site outside the lattice) goes from the
//   divide state straight to commit; an update first walks the address,
//   read and last states, paced by the single read port of the spin store,
//   which delivers the five words one per cycle. The block takes one command
//   at a time: ready returns in the cycle the result appears.
// Reset and stall:
//   Reset returns the sequencer to idle and empties the result register; the
//   spin store keeps no reset value. While out_o is stalled, a new command
//   is still accepted and processed up to its commit, which then waits for
//   the result register to free.
// ----------------------------------------------------------------------------
module ising_lattice_site_update #(
  parameter int unsigned SIDE         = 16,
  parameter int unsigned REALIZATIONS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ilsu_in_if.sink           in_i,
  ilsu_out_if.source        out_o
);
  import ilsu_pkg::*;

  ilsu_cmd_t cmd;
  ilsu_sts_t sts;

  // Sequencer
  ilsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath and spin store
  ilsu_datapath #(
    .SIDE         (SIDE),
    .REALIZATIONS (REALIZATIONS)
  ) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .command_i   (in_i.command),
    .site_i      (in_i.site),
    .threshold_i (in_i.threshold),
    .load_word_i (in_i.load_word),
    .out_site_o  (out_o.out_site),
    .spin_word_o (out_o.spin_word),
    .flip_mask_o (out_o.flip_mask)
  );

endmodule

>>> hw/rtl/ilsu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsu_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ilsu_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage and registered read, no reset on contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ilsu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsu_datapath
// Item registers, neighbour addressing, spin store, per-realization flip
// decision and result register.
// ----------------------------------------------------------------------------
module ilsu_datapath #(
  parameter int unsigned SIDE         = 16,
  parameter int unsigned REALIZATIONS = 64
) (
  input  logic                      clk_i,
  input  ilsu_pkg::ilsu_cmd_t       cmd_i,
  output ilsu_pkg::ilsu_sts_t       sts_o,
  input  logic                      command_i,
  input  logic [ilsu_pkg::SITE_W-1:0] site_i,
  input  logic [ilsu_pkg::THR_W-1:0]  threshold_i,
  input  logic [ilsu_pkg::WORD_W-1:0] load_word_i,
  output logic [ilsu_pkg::SITE_W-1:0] out_site_o,
  output logic [ilsu_pkg::WORD_W-1:0] spin_word_o,
  output logic [ilsu_pkg::WORD_W-1:0] flip_mask_o
);
  import ilsu_pkg::*;

  localparam int unsigned R      = REALIZATIONS;
  localparam int unsigned SITES  = SIDE * SIDE;
  // Only sites below 256 are addressable by an 8-bit site index
  localparam int unsigned DEPTH  = (SITES < 256) ? SITES : 256;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned IW     = $clog2(SITES) + 1;
  localparam int unsigned XW     = $clog2(SIDE);
  // Reciprocal of SIDE, exact floor for 8-bit sites
  localparam int unsigned RSH    = 16;
  localparam int unsigned RECIP  = ((1 << RSH) + SIDE - 1) / SIDE;
  localparam int unsigned RW     = $clog2(RECIP + 1);
  localparam int unsigned PW     = SITE_W + RW;

  // Latched item
  logic              cmd_q;
  logic [SITE_W-1:0] site_q;
  logic [THR_W-1:0]  thr_q;
  logic [R-1:0]      load_q;
  logic              in_range_q;

  // Row number and read addresses
  logic [SITE_W-1:0] y_q;
  logic [AW-1:0]     addr_q [NB_WORDS];
  logic [R-1:0]      word_q [NB_WORDS];

  logic [SITE_W-1:0] out_site_q;
  logic [R-1:0]      out_word_q;
  logic [R-1:0]      out_flip_q;

  logic [PW-1:0]     prod;
  logic [15:0]       row_prod;
  logic [SITE_W-1:0] row_base;
  logic [XW-1:0]     x;
  logic [XW-1:0]     x_rt;
  logic [XW-1:0]     x_lf;
  logic [IW-1:0]     base_up;
  logic [IW-1:0]     base_dn;
  logic [IW-1:0]     idx [NB_WORDS];

  logic [AW-1:0]     rd_addr;
  logic [R-1:0]      rd_data;
  logic [R-1:0]      flip;
  logic [R-1:0]      res_word;
  logic [R-1:0]      res_flip;
  logic signed [4:0] thr_s;

  // Row number by reciprocal multiply
  assign prod = PW'(site_q) * PW'(RECIP);

  // Column and wrapped neighbour indices
  always_comb begin
    row_prod = 16'(y_q) * 16'(SIDE);
    row_base = row_prod[SITE_W-1:0];
    x        = XW'(site_q - row_base);
    x_rt     = (x == XW'(SIDE - 1)) ? '0 : XW'(x + 1'b1);
    x_lf     = (x == '0) ? XW'(SIDE - 1) : XW'(x - 1'b1);
    base_up  = (y_q == SITE_W'(SIDE - 1)) ? '0 : IW'(row_base) + IW'(SIDE);
    base_dn  = (y_q == '0) ? IW'(SITES - SIDE) : IW'(row_base) - IW'(SIDE);
    idx[0]   = IW'(site_q);
    idx[1]   = IW'(row_base) + IW'(x_rt);
    idx[2]   = IW'(row_base) + IW'(x_lf);
    idx[3]   = base_up + IW'(x);
    idx[4]   = base_dn + IW'(x);
  end

  // Item, address and word registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cmd_q      <= command_i;
      site_q     <= site_i;
      thr_q      <= threshold_i;
      load_q     <= load_word_i[R-1:0];
      in_range_q <= (16'(site_i) < 16'(SITES));
    end
    if (cmd_i.div) begin
      y_q <= SITE_W'(prod >> RSH);
    end
    if (cmd_i.nbr) begin
      for (int k = 0; k < NB_WORDS; k++) begin
        addr_q[k] <= idx[k][AW-1:0];
      end
    end
    if (cmd_i.cap_en) begin
      word_q[cmd_i.cap_sel] <= rd_data;
    end
  end

  assign sts_o.upd_go = (cmd_q == CMD_UPDATE) && in_range_q;

  // Spin store
  assign rd_addr = addr_q[cmd_i.rd_sel];

  ilsu_ram #(
    .WIDTH (R),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && in_range_q),
    .waddr_i (site_q[AW-1:0]),
    .wdata_i (res_word),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Threshold saturates at the largest energy term
  assign thr_s = (thr_q > 8'd4) ? 5'sd4 : $signed({2'b00, thr_q[2:0]});

  // Per-realization Metropolis decision
  for (genvar r = 0; r < R; r++) begin : g_lane
    logic [2:0]        up_cnt;
    logic signed [4:0] nb_sum;
    logic signed [4:0] term;

    assign up_cnt = 3'(word_q[1][r]) + 3'(word_q[2][r])
                  + 3'(word_q[3][r]) + 3'(word_q[4][r]);
    assign nb_sum = $signed({1'b0, up_cnt, 1'b0}) - 5'sd4;
    assign term   = word_q[0][r] ? nb_sum : -nb_sum;
    assign flip[r] = (thr_s >= term);
  end

  // Result selection
  always_comb begin
    res_word = '0;
    res_flip = '0;
    if (in_range_q) begin
      if (cmd_q == CMD_LOAD) begin
        res_word = load_q;
      end else begin
        res_word = word_q[0] ^ flip;
        res_flip = flip;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_site_q <= site_q;
      out_word_q <= res_word;
      out_flip_q <= res_flip;
    end
  end

  assign out_site_o  = out_site_q;
  assign spin_word_o = WORD_W'(out_word_q);
  assign flip_mask_o = WORD_W'(out_flip_q);

endmodule

>>> hw/rtl/ilsu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsu_ctrl
// Sequencer: accepts an item, walks the five store reads for an update and
// commits the result into the output register.
// ----------------------------------------------------------------------------
module ilsu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ilsu_pkg::ilsu_cmd_t cmd_o,
  input  ilsu_pkg::ilsu_sts_t sts_i
);
  import ilsu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_NBR,
    S_READ,
    S_LAST,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [SEL_W-1:0] cnt_q, cnt_d;
  logic             cap_en_q, cap_en_d;
  logic [SEL_W-1:0] cap_sel_q, cap_sel_d;
  logic             out_valid_q, out_valid_d;
  logic             take;
  logic             commit;

  assign in_ready_o = (state_q == S_IDLE);
  assign take       = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cap_en_d    = 1'b0;
    cap_sel_d   = cap_sel_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        state_d = sts_i.upd_go ? S_NBR : S_DONE;
      end
      S_NBR: begin
        cnt_d   = '0;
        state_d = S_READ;
      end
      S_READ: begin
        cap_en_d  = 1'b1;
        cap_sel_d = cnt_q;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == SEL_W'(NB_WORDS - 1)) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (commit) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cap_en_q    <= 1'b0;
      cap_sel_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cap_en_q    <= cap_en_d;
      cap_sel_q   <= cap_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath commands
  always_comb begin
    cmd_o.take    = take;
    cmd_o.div     = (state_q == S_DIV);
    cmd_o.nbr     = (state_q == S_NBR);
    cmd_o.rd_sel  = (state_q == S_READ) ? cnt_q : '0;
    cmd_o.cap_en  = cap_en_q;
    cmd_o.cap_sel = cap_sel_q;
    cmd_o.commit  = commit;
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> bench/ising_lattice_site_update_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_lattice_site_update_test
// Self-checking bench for the lattice site update block. Loads and updates
// are sent over the command channel. A local copy of the lattice predicts
// each result, and every returned transfer is compared with the oldest
// pending prediction. Both channels idle in random bursts; the run ends
// with a stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module ising_lattice_site_update_test;
  import ilsu_pkg::*;

  localparam int unsigned SIDE         = 16;
  localparam int unsigned REALIZATIONS = 64;
  localparam int unsigned SITES        = SIDE * SIDE;
  localparam logic [WORD_W-1:0] REAL_MASK =
    (REALIZATIONS >= WORD_W) ? {WORD_W{1'b1}} : ((64'd1 << REALIZATIONS) - 64'd1);

  // Expected content of one result transfer
  typedef struct packed {
    logic [SITE_W-1:0] site;
    logic [WORD_W-1:0] spin;
    logic [WORD_W-1:0] flips;
  } site_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  site_result_t      pending_results [$];
  logic [WORD_W-1:0] lattice [SITES];
  int unsigned       error_count = 0;
  bit                idle_en     = 1'b1;
  int unsigned       stall_left  = 0;
  site_result_t      got_result;

  ilsu_in_if  cmd_if ();
  ilsu_out_if res_if ();

  ising_lattice_site_update #(
    .SIDE         (SIDE),
    .REALIZATIONS (REALIZATIONS)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Wrapped neighbour: 0 right, 1 left, 2 up (y + 1), 3 down (y - 1)
  function automatic int unsigned neighbour_site(int unsigned s, int unsigned k);
    int unsigned x;
    int unsigned y;
    x = s % SIDE;
    y = s / SIDE;
    case (k)
      0:       return (x + 1) % SIDE + SIDE * y;
      1:       return (x + SIDE - 1) % SIDE + SIDE * y;
      2:       return x + SIDE * ((y + 1) % SIDE);
      default: return x + SIDE * ((y + SIDE - 1) % SIDE);
    endcase
  endfunction

  // Applies one command to the local lattice and returns the expected result
  function automatic site_result_t apply_site_command(logic cmd, logic [SITE_W-1:0] site,
                                                      logic [THR_W-1:0] thr,
                                                      logic [WORD_W-1:0] word);
    site_result_t      res;
    logic [WORD_W-1:0] self_w;
    logic [WORD_W-1:0] nb [4];
    int                sum;
    int                term;
    int                r;
    int                k;
    res.site  = site;
    res.spin  = '0;
    res.flips = '0;
    if (site < SITES) begin
      if (cmd == CMD_LOAD) begin
        res.spin = word & REAL_MASK;
      end else begin
        self_w = lattice[site];
        for (k = 0; k < 4; k++) nb[k] = lattice[neighbour_site(site, k)];
        for (r = 0; r < REALIZATIONS; r++) begin
          sum = 0;
          for (k = 0; k < 4; k++) sum += nb[k][r] ? 1 : -1;
          term = self_w[r] ? sum : -sum;
          if (int'(thr) >= term) res.flips[r] = 1'b1;
        end
        res.flips = res.flips & REAL_MASK;
        res.spin  = (self_w ^ res.flips) & REAL_MASK;
      end
      lattice[site] = res.spin;
    end
    return res;
  endfunction

  // Appends one prediction behind the older ones
  function automatic void queue_expected(site_result_t res);
    pending_results.insert(pending_results.size(), res);
  endfunction

  // One command transfer, with an optional idle burst in front of it
  task automatic send_command(logic cmd, logic [SITE_W-1:0] site, logic [THR_W-1:0] thr,
                              logic [WORD_W-1:0] word);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.command   <= cmd;
    cmd_if.site      <= site;
    cmd_if.threshold <= thr;
    cmd_if.load_word <= word;
    do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
    queue_expected(apply_site_command(cmd, site, thr, word));
  endtask

  task automatic wait_results_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] rand_spin_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      3:       return ~(64'd1 << $urandom_range(0, 63));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Mostly near the energy range, sometimes anywhere
  function automatic logic [THR_W-1:0] rand_threshold();
    if ($urandom_range(0, 9) < 7) return THR_W'($urandom_range(0, 5));
    return THR_W'($urandom_range(0, 255));
  endfunction

  // Site 0 and its neighbours hold every spin combination once per 32
  // realizations, so each energy term from -4 to 4 occurs in the first update
  task automatic test_energy_terms();
    logic [WORD_W-1:0] pattern [5];
    int                r;
    int                k;
    for (k = 0; k < 5; k++) begin
      pattern[k] = '0;
      for (r = 0; r < REALIZATIONS; r++) pattern[k][r] = 1'((r >> k) & 1);
    end
    send_command(CMD_LOAD, 8'd0, 8'd0, pattern[0]);
    for (k = 0; k < 4; k++)
      send_command(CMD_LOAD, SITE_W'(neighbour_site(0, k)), 8'hff, pattern[k + 1]);
    for (k = 0; k <= 4; k++) send_command(CMD_UPDATE, 8'd0, THR_W'(k), '0);
    send_command(CMD_LOAD, 8'd0, 8'd0, pattern[0]);
    send_command(CMD_UPDATE, 8'd0, 8'hff, '1);
  endtask

  // Last site: its right and up neighbours wrap around the lattice edge
  task automatic test_wrap_corner();
    send_command(CMD_LOAD, 8'd255, 8'd0, '1);
    send_command(CMD_LOAD, SITE_W'(neighbour_site(255, 0)), 8'd0, '1);
    send_command(CMD_LOAD, SITE_W'(neighbour_site(255, 1)), 8'd0, '0);
    send_command(CMD_LOAD, SITE_W'(neighbour_site(255, 2)), 8'd0, 64'haaaa_5555_f0f0_0f0f);
    send_command(CMD_LOAD, SITE_W'(neighbour_site(255, 3)), 8'd0, 64'hffff_0000_cccc_3333);
    send_command(CMD_UPDATE, 8'd255, 8'd0, '0);
    send_command(CMD_UPDATE, 8'd255, 8'd128, '0);
    send_command(CMD_UPDATE, 8'd255, 8'd2, '1);
  endtask

  // Every site written, so any later update reads defined words only
  task automatic test_lattice_fill();
    int s;
    for (s = 0; s < SITES; s++)
      send_command(CMD_LOAD, SITE_W'(s), THR_W'($urandom()), rand_spin_word());
  endtask

  task automatic test_random_mix(int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      if (i % 250 == 125) wait_results_drained();
      if ($urandom_range(0, 3) == 0)
        send_command(CMD_LOAD, SITE_W'($urandom()), THR_W'($urandom()), rand_spin_word());
      else
        send_command(CMD_UPDATE, SITE_W'($urandom()), rand_threshold(), {$urandom(), $urandom()});
    end
  endtask

  task automatic test_back_to_back(int unsigned count);
    idle_en = 1'b0;
    test_random_mix(count);
  endtask

  // Result side: random stall bursts while idling is enabled
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [WORD_W-1:0] exp, logic [WORD_W-1:0] act);
    if (exp !== act) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      error_count++;
    end
  endtask

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual site %0d", $time,
                 res_if.out_site);
        error_count++;
      end else begin
        got_result = pending_results.pop_front();
        check_field("out_site", WORD_W'(got_result.site), WORD_W'(res_if.out_site));
        check_field("spin_word", got_result.spin, res_if.spin_word);
        check_field("flip_mask", got_result.flips, res_if.flip_mask);
      end
    end
  end

  // Main sequence
  initial begin
    cmd_if.valid     <= 1'b0;
    cmd_if.command   <= CMD_LOAD;
    cmd_if.site      <= '0;
    cmd_if.threshold <= '0;
    cmd_if.load_word <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_energy_terms();
    test_wrap_corner();
    test_lattice_fill();
    test_random_mix(750);
    test_back_to_back(150);

    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("ising_lattice_site_update_test passed");
    end else begin
      $display("ising_lattice_site_update_test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("ising_lattice_site_update_test failed");
    $finish;
  end

endmodule

>>> ising_lattice_site_update.f
hw/rtl/ilsu_pkg.sv
hw/rtl/ilsu_in_if.sv
hw/rtl/ilsu_out_if.sv
hw/rtl/ilsu_ram.sv
hw/rtl/ilsu_datapath.sv
hw/rtl/ilsu_ctrl.sv
hw/rtl/ising_lattice_site_update.sv
bench/ising_lattice_site_update_test.sv
